// ===== rtl/core/prl_pkg.sv =====
package prl_pkg;

  localparam int NORM_SIZE = 256;
  localparam int EXT_SIZE  = 1024;
  localparam int NORM_AW   = $clog2(NORM_SIZE);
  localparam int EXT_AW    = $clog2(EXT_SIZE);

  localparam logic [15:0] UNTRACKED_OPCODE = 16'h00D0;
  localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;

  localparam logic [2:0] V_UNTRACKED = 3'd0;
  localparam logic [2:0] V_FIRST     = 3'd1;
  localparam logic [2:0] V_PASS      = 3'd2;
  localparam logic [2:0] V_TOTAL     = 3'd3;
  localparam logic [2:0] V_OPLIMIT   = 3'd4;
  localparam logic [2:0] V_SOON      = 3'd5;
  localparam logic [2:0] V_BADOP     = 3'd6;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_TOTAL_LIMIT   = 1'b1;

  typedef struct packed {
    logic accept;
    logic rd_reg;
    logic exec;
    logic close;
    logic clr;
    logic clr_all;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic out_busy;
    logic clr_done;
  } status_t;

endpackage

// ===== rtl/core/prl_ctrl.sv =====
module prl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  prl_pkg::status_t st,
  output prl_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_EXE  = 5'b00100,
    S_CLR  = 5'b01000,
    S_RD   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.clr     = 1'b1;
        cmd.clr_all = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = S_EXE;
      end
      S_EXE: begin
        if (st.close) begin
          cmd.close  = 1'b1;
          state_next = S_CLR;
        end else if (!st.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_reg = 1'b1;
        state_next = S_EXE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/prl_dp.sv =====
module prl_dp (
  input  logic             clk,
  input  logic             rst,
  input  prl_pkg::cmd_t    cmd,
  output prl_pkg::status_t st,
  input  logic [119:0]     s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic [31:0]      window_length,
  input  logic [31:0]      total_packet_limit,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata
);

  logic        cmd_r, sel_r, pay_r;
  logic [15:0] op_r;
  logic [31:0] now_r, lc_r, ls_r;

  logic [31:0] window_start, total_count;
  logic [prl_pkg::EXT_AW-1:0] clr_cnt, clr_last;

  logic [63:0] ncl_mem [prl_pkg::NORM_SIZE];
  logic [63:0] ecl_mem [prl_pkg::EXT_SIZE];
  logic [63:0] nlim_mem [prl_pkg::NORM_SIZE];
  logic [63:0] elim_mem [prl_pkg::EXT_SIZE];
  logic [63:0] ncl_q, ecl_q, nlim_q, elim_q;

  logic        rd_en;
  logic [15:0] rd_op;
  logic [63:0] cl, lim;
  logic [31:0] cnt, last, cnt_inc, tot_inc, maxc, minsp;
  logic        in_range, untracked, tracked;
  logic        allowed_c, cl_we, tot_we, lim_we;
  logic [2:0]  verdict_c;
  logic [63:0] cl_wdata;
  logic        ncl_we, ecl_we, nlim_we, elim_we;
  logic [63:0] cl_wd, lim_wd;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= s_tuser[0];
      sel_r <= s_tuser[1];
      op_r  <= s_tdata[15:0];
      now_r <= s_tdata[47:16];
      pay_r <= s_tdata[48];
      lc_r  <= s_tdata[80:49];
      ls_r  <= s_tdata[112:81];
    end
  end

  assign rd_en = cmd.accept || cmd.rd_reg;
  assign rd_op = cmd.accept ? s_tdata[15:0] : op_r;

  assign cl  = sel_r ? ecl_q : ncl_q;
  assign lim = sel_r ? elim_q : nlim_q;
  assign cnt   = cl[31:0];
  assign last  = cl[63:32];
  assign maxc  = lim[31:0];
  assign minsp = lim[63:32];
  assign cnt_inc = (cnt == prl_pkg::SAT32) ? prl_pkg::SAT32 : cnt + 32'd1;
  assign tot_inc = (total_count == prl_pkg::SAT32) ? prl_pkg::SAT32 : total_count + 32'd1;

  assign in_range  = sel_r ? ({1'b0, op_r} < 17'(prl_pkg::EXT_SIZE))
                           : ({1'b0, op_r} < 17'(prl_pkg::NORM_SIZE));
  assign untracked = !pay_r || (!sel_r && op_r == prl_pkg::UNTRACKED_OPCODE);
  assign tracked   = !cmd_r && !untracked && in_range;

  assign st.close    = tracked && ((now_r - window_start) > window_length);
  assign st.out_busy = m_tvalid && !m_tready;
  assign clr_last    = (cmd.clr_all || sel_r) ? prl_pkg::EXT_AW'(prl_pkg::EXT_SIZE - 1)
                                              : prl_pkg::EXT_AW'(prl_pkg::NORM_SIZE - 1);
  assign st.clr_done = (clr_cnt == clr_last);

  always_comb begin
    allowed_c = 1'b0;
    verdict_c = prl_pkg::V_BADOP;
    cl_we     = 1'b0;
    tot_we    = 1'b0;
    lim_we    = 1'b0;
    cl_wdata  = {last, cnt_inc};
    if (cmd_r) begin
      if (in_range) begin
        lim_we    = 1'b1;
        allowed_c = 1'b1;
        verdict_c = prl_pkg::V_UNTRACKED;
      end
    end else if (untracked) begin
      allowed_c = 1'b1;
      verdict_c = prl_pkg::V_UNTRACKED;
    end else if (in_range) begin
      tot_we = 1'b1;
      if (tot_inc > total_packet_limit) begin
        verdict_c = prl_pkg::V_TOTAL;
      end else if (cnt == 32'd0) begin
        cl_we     = 1'b1;
        cl_wdata  = {now_r, 32'd1};
        allowed_c = 1'b1;
        verdict_c = prl_pkg::V_FIRST;
      end else begin
        cl_we = 1'b1;
        if (maxc != 32'd0 && cnt_inc > maxc) begin
          verdict_c = prl_pkg::V_OPLIMIT;
        end else if (minsp != 32'd0 && (now_r - last) < minsp) begin
          verdict_c = prl_pkg::V_SOON;
        end else begin
          cl_wdata  = {now_r, cnt_inc};
          allowed_c = 1'b1;
          verdict_c = prl_pkg::V_PASS;
        end
      end
    end
  end

  // clearing walk shares the write ports with the update
  assign ncl_we  = (cmd.clr && (cmd.clr_all || !sel_r)) || (cmd.exec && cl_we && !sel_r);
  assign ecl_we  = (cmd.clr && (cmd.clr_all || sel_r)) || (cmd.exec && cl_we && sel_r);
  assign nlim_we = (cmd.clr && cmd.clr_all) || (cmd.exec && lim_we && !sel_r);
  assign elim_we = (cmd.clr && cmd.clr_all) || (cmd.exec && lim_we && sel_r);
  assign cl_wd   = cmd.clr ? 64'd0 : cl_wdata;
  assign lim_wd  = cmd.clr ? 64'd0 : {ls_r, lc_r};

  always_ff @(posedge clk) begin
    if (ncl_we) begin
      ncl_mem[cmd.clr ? clr_cnt[prl_pkg::NORM_AW-1:0] : op_r[prl_pkg::NORM_AW-1:0]] <= cl_wd;
    end
    if (rd_en) ncl_q <= ncl_mem[rd_op[prl_pkg::NORM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ecl_we) begin
      ecl_mem[cmd.clr ? clr_cnt : op_r[prl_pkg::EXT_AW-1:0]] <= cl_wd;
    end
    if (rd_en) ecl_q <= ecl_mem[rd_op[prl_pkg::EXT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nlim_we) begin
      nlim_mem[cmd.clr ? clr_cnt[prl_pkg::NORM_AW-1:0] : op_r[prl_pkg::NORM_AW-1:0]] <= lim_wd;
    end
    if (rd_en) nlim_q <= nlim_mem[rd_op[prl_pkg::NORM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (elim_we) begin
      elim_mem[cmd.clr ? clr_cnt : op_r[prl_pkg::EXT_AW-1:0]] <= lim_wd;
    end
    if (rd_en) elim_q <= elim_mem[rd_op[prl_pkg::EXT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      window_start <= '0;
      total_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= st.clr_done ? '0 : clr_cnt + prl_pkg::EXT_AW'(1);
      end
      if (cmd.close) begin
        window_start <= now_r;
        total_count  <= '0;
      end else if (cmd.exec && tot_we) begin
        total_count <= tot_inc;
      end
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) m_tdata <= {4'd0, verdict_c, allowed_c};
  end

endmodule

// ===== rtl/core/per_opcode_packet_rate_limiter.sv =====
// per-opcode packet rate limiter
// input stream s_*: one transfer is a packet check or a limit-entry write;
//   tuser selects the command and the table, tdata carries opcode, tick,
//   payload flag and the limits for a write
// output stream m_*: one transfer per input item with allowed and verdict
// apb port: window_length at 0x0, total_packet_limit at 0x4, always ready
// each item is first accepted with its opcode entry read, then decided with
//   the entry written back before the next item is accepted; the decision
//   loads the output register
// a check that closes the window first walks the selected count table clearing
//   it, one entry a cycle: 256 entries normal, 1024 extended, then one re-read
// after reset a clearing pass over 1024 entries zeroes all tables; s_tready is
//   low meanwhile, configuration writes are taken as ever
// while m_tready is low with a result waiting, the next item is accepted and
//   read but holds before its decision until the output register frees
module per_opcode_packet_rate_limiter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[15:0], now_tick[47:16], has_payload[48], limit_count[80:49],
  // limit_spacing[112:81], zero fill
  input  logic [119:0] s_tdata,
  // cmd[0], table_select[1]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // allowed[0], verdict[3:1], zero fill
  output logic [7:0]   m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] window_length, total_packet_limit;
  prl_pkg::cmd_t    cmd;
  prl_pkg::status_t st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= 32'd1000;
      total_packet_limit <= 32'd100;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        prl_pkg::REG_WINDOW_LENGTH: window_length      <= pwdata;
        prl_pkg::REG_TOTAL_LIMIT:   total_packet_limit <= pwdata;
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == prl_pkg::REG_TOTAL_LIMIT) ? total_packet_limit
                                                         : window_length;

  prl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  prl_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .window_length      (window_length),
    .total_packet_limit (total_packet_limit),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata)
  );

endmodule

// ===== sim/tb.sv =====
module tb;

  localparam int CYCLE_LIMIT = 10000000;

  class admission_scoreboard;
    bit [31:0] win_len, tot_limit;
    bit [31:0] win_start, tot_count;
    bit [31:0] norm_cnt[prl_pkg::NORM_SIZE];
    bit [31:0] norm_last[prl_pkg::NORM_SIZE];
    bit [63:0] norm_lim[prl_pkg::NORM_SIZE];
    bit [31:0] ext_cnt[prl_pkg::EXT_SIZE];
    bit [31:0] ext_last[prl_pkg::EXT_SIZE];
    bit [63:0] ext_lim[prl_pkg::EXT_SIZE];
    bit [3:0]  verdict_q[$];
    int        errors;
    int        checked;

    function new();
      win_len   = 32'd1000;
      tot_limit = 32'd100;
      win_start = '0;
      tot_count = '0;
      foreach (norm_cnt[i]) begin
        norm_cnt[i] = '0; norm_last[i] = '0; norm_lim[i] = '0;
      end
      foreach (ext_cnt[i]) begin
        ext_cnt[i] = '0; ext_last[i] = '0; ext_lim[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function bit [31:0] sat_up(bit [31:0] v);
      return (v == prl_pkg::SAT32) ? prl_pkg::SAT32 : v + 32'd1;
    endfunction

    function void push(bit allowed, logic [2:0] verdict);
      verdict_q.push_back({verdict, allowed});
    endfunction

    function void note_packet(bit cmd, bit ext, bit [15:0] op, bit [31:0] now, bit pay,
                              bit [31:0] lc, bit [31:0] ls);
      int unsigned size;
      bit [31:0] cnt, last, max_cnt, min_gap;
      bit [63:0] lim;
      size = ext ? prl_pkg::EXT_SIZE : prl_pkg::NORM_SIZE;
      if (cmd) begin
        if (op >= size) push(1'b0, prl_pkg::V_BADOP);
        else begin
          if (ext) ext_lim[op] = {ls, lc};
          else norm_lim[op] = {ls, lc};
          push(1'b1, prl_pkg::V_UNTRACKED);
        end
        return;
      end
      if (!pay || (!ext && op == prl_pkg::UNTRACKED_OPCODE)) begin
        push(1'b1, prl_pkg::V_UNTRACKED);
        return;
      end
      if (op >= size) begin
        push(1'b0, prl_pkg::V_BADOP);
        return;
      end
      if ((now - win_start) > win_len) begin
        win_start = now;
        tot_count = '0;
        if (ext) foreach (ext_cnt[i]) begin ext_cnt[i] = '0; ext_last[i] = '0; end
        else foreach (norm_cnt[i]) begin norm_cnt[i] = '0; norm_last[i] = '0; end
      end
      tot_count = sat_up(tot_count);
      if (tot_count > tot_limit) begin
        push(1'b0, prl_pkg::V_TOTAL);
        return;
      end
      cnt  = ext ? ext_cnt[op] : norm_cnt[op];
      last = ext ? ext_last[op] : norm_last[op];
      lim  = ext ? ext_lim[op] : norm_lim[op];
      if (cnt == 0) begin
        cnt = 32'd1;
        last = now;
        push(1'b1, prl_pkg::V_FIRST);
      end else begin
        cnt = sat_up(cnt);
        max_cnt = lim[31:0];
        min_gap = lim[63:32];
        if (max_cnt != 0 && cnt > max_cnt) push(1'b0, prl_pkg::V_OPLIMIT);
        else if (min_gap != 0 && (now - last) < min_gap) push(1'b0, prl_pkg::V_SOON);
        else begin
          last = now;
          push(1'b1, prl_pkg::V_PASS);
        end
      end
      if (ext) begin ext_cnt[op] = cnt; ext_last[op] = last; end
      else begin norm_cnt[op] = cnt; norm_last[op] = last; end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_verdict(logic [7:0] data);
      bit [3:0] want;
      checked++;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      want = verdict_q.pop_front();
      if (data[0] !== want[0])
        report($sformatf("result %0d allowed %b want %b", checked, data[0], want[0]));
      if (data[3:1] !== want[3:1])
        report($sformatf("result %0d verdict %0d want %0d", checked, data[3:1], want[3:1]));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  per_opcode_packet_rate_limiter dut (.*);

  admission_scoreboard sb = new();
  int        cycles = 0;
  int        burst_left = 0;
  int        sent = 0;
  int        closes_seen = 0;
  bit        holdoff_req = 1'b0;
  bit [31:0] tick = 32'd0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("per_opcode_packet_rate_limiter test failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);

  // receiver: segments of differing readiness, plus one long hold-off on request
  initial begin : receiver
    int seg, pct, hold;
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          m_tready <= 1'b0;
          hold++;
        end
      end
      seg = $urandom_range(5, 60);
      case ($urandom_range(0, 2))
        0: pct = 100;
        1: pct = 70;
        default: pct = 25;
      endcase
      repeat (seg) begin
        @(posedge clk);
        m_tready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  task apb_write(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task set_limits(logic [31:0] wl, logic [31:0] tl);
    apb_write({prl_pkg::REG_WINDOW_LENGTH, 2'b00}, wl);
    sb.win_len = wl;
    apb_write({prl_pkg::REG_TOTAL_LIMIT, 2'b00}, tl);
    sb.tot_limit = tl;
  endtask

  task wait_drained();
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task send_item(bit cmd, bit ext, bit [15:0] op, bit [31:0] now, bit pay,
                 bit [31:0] lc, bit [31:0] ls);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {ext, cmd};
    s_tdata  <= {7'b0, ls, lc, pay, now, op};
    do @(posedge clk); while (!s_tready);
    if (!cmd && pay && !(!ext && op == prl_pkg::UNTRACKED_OPCODE) &&
        op < (ext ? prl_pkg::EXT_SIZE : prl_pkg::NORM_SIZE) &&
        (now - sb.win_start) > sb.win_len) closes_seen++;
    sb.note_packet(cmd, ext, op, now, pay, lc, ls);
    burst_left--;
    sent++;
  endtask

  task end_burst();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task random_item(int max_step);
    bit        cmd, ext, pay;
    bit [15:0] op;
    bit [31:0] lc, ls;
    int        r;
    r   = $urandom_range(0, 99);
    cmd = (r < 10);
    ext = 1'($urandom_range(0, 1));
    pay = ($urandom_range(0, 9) != 0);
    r   = $urandom_range(0, 99);
    if (r < 80) op = 16'($urandom_range(0, 15));
    else if (r < 85) op = prl_pkg::UNTRACKED_OPCODE;
    else op = 16'($urandom);
    lc = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom;
    ls = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom;
    if ($urandom_range(0, 199) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, max_step);
    send_item(cmd, ext, op, tick, pay, lc, ls);
  endtask

  task random_phase(int n, int max_step);
    repeat (n) random_item(max_step);
    end_burst();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    tick = 32'd10;
    send_item(1'b1, 1'b0, 16'd1, tick, 1'b1, 32'd3, 32'd5);
    send_item(1'b1, 1'b1, 16'd3, tick, 1'b0, 32'd0, 32'd10);
    send_item(1'b1, 1'b0, 16'd256, tick, 1'b1, 32'd1, 32'd1);
    send_item(1'b1, 1'b1, 16'd1024, tick, 1'b1, 32'd1, 32'd1);
    send_item(1'b1, 1'b1, 16'hFFFF, tick, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 1'b0, 16'd1, tick, 1'b0, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, prl_pkg::UNTRACKED_OPCODE, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, prl_pkg::UNTRACKED_OPCODE, tick, 1'b1, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(1'b0, 1'b0, 16'd1, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd2, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd6, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd20, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd30, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, 16'd3, tick + 32'd30, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, 16'd3, tick + 32'd35, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd300, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, 16'hFFFF, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, 16'd1023, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd255, tick, 1'b1, 32'd0, 32'd0);
    // jump past the window so it closes on the extended table, then the normal one
    tick = tick + 32'd2000;
    send_item(1'b0, 1'b1, 16'd3, tick, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd1500, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, 16'd1, tick + 32'd1500, 1'b1, 32'd0, 32'd0);
    tick = tick + 32'd1500;
    end_burst();
    wait_drained();

    // small total limit shows total rejects
    set_limits(32'd40, 32'd5);
    random_phase(325, 2);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    holdoff_req = 1'b1;
    random_phase(325, 3);
    set_limits(32'd0, 32'd0);
    random_phase(120, 1);
    set_limits(32'd200, 32'd60);
    random_phase(400, 3);
    set_limits(32'd7, 32'd3);
    random_phase(325, 1);
    set_limits(32'd1000, 32'd100);
    random_phase(450, 4);

    repeat (1200) @(posedge clk);
    if (sb.verdict_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.verdict_q.size()));
    $display("covered %0d transfers (%0d results checked) over six limit settings",
             sent, sb.checked);
    $display("window closes predicted: %0d, including a long output hold-off", closes_seen);
    if (sb.errors == 0) $display("per_opcode_packet_rate_limiter test passed");
    else $display("per_opcode_packet_rate_limiter test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/prl_pkg.sv
rtl/core/prl_ctrl.sv
rtl/core/prl_dp.sv
rtl/core/per_opcode_packet_rate_limiter.sv
sim/tb.sv
